[design/dmajl_pkg.sv]
// Shared types, codes and the microcode ROM of the job-list DMA engine.
`timescale 1ns / 1ps
`default_nettype none
package dmajl_pkg;

  typedef logic [4:0] step_t;

  // Fields of one input transfer and one result transfer, engine phases and job modes
  typedef enum logic [1:0] {
    OP_REG_WR   = 2'd0,
    OP_REG_RD   = 2'd1,
    OP_MEM_DATA = 2'd2,
    OP_MEM_ACK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OFF_LOW  = 2'd0,
    OFF_MID  = 2'd1,
    OFF_BANK = 2'd2,
    OFF_NONE = 2'd3
  } reg_off_e;

  typedef enum logic [1:0] {
    K_RD_REQ   = 2'd0,
    K_WR_REQ   = 2'd1,
    K_DONE     = 2'd2,
    K_REG_DATA = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FETCH = 2'd1,
    PH_READ  = 2'd2,
    PH_WRITE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    MODE_UP    = 3'd0,
    MODE_DSTDN = 3'd1,
    MODE_SRCDN = 3'd2,
    MODE_FILL  = 3'd4,
    MODE_DOWN  = 3'd5
  } mode_e;

  localparam logic [7:0]  CMD_COPY   = 8'h00;
  localparam logic [7:0]  CMD_FILL   = 8'h03;
  localparam logic [7:0]  CMD_DOWN   = 8'h30;
  localparam logic [7:0]  READ_VALUE = 8'h7f;
  localparam logic [3:0]  JOB_BYTES  = 4'd9;
  localparam logic [23:0] DIR_BIT    = 24'h400000;
  localparam logic [1:0]  VERSION_DIR = 2'd1;
  localparam logic [1:0]  VERSION_RST = 2'd2;

  // Microcode fields
  typedef enum logic [1:0] {
    J_NEXT,   // step + 1
    J_IF,     // condition ? target : step + 1
    J_WAIT,   // transfer accepted ? target : stay
    J_DISP    // dispatch base + operation
  } jmp_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_PH_BUSY,
    C_OFF_NZ,
    C_PH_FETCH,
    C_PH_NOT_READ,
    C_FETCH_MORE,
    C_COUNT_ZERO,
    C_CMD_UNKNOWN,
    C_MODE_NOT_FILL,
    C_PH_NOT_WRITE,
    C_COUNT_NZ
  } cond_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_LP_WRITE,
    A_FETCH_START,
    A_STORE_BYTE,
    A_MASK_ADDR,
    A_SET_MODE,
    A_FILL_WRITE,
    A_SRC_READ,
    A_COPY_WRITE,
    A_GO_IDLE,
    A_DEC_COUNT
  } act_e;

  typedef enum logic [2:0] {
    E_NONE,
    E_REG_READ,
    E_FETCH_REQ,
    E_COPY_WRITE,
    E_FILL_WRITE,
    E_SRC_READ,
    E_FINISH
  } emit_e;

  typedef struct packed {
    jmp_e  jmp;
    cond_e cnd;
    step_t target;
    act_e  act;
    emit_e emit;
  } uword_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic ph_idle;
    logic ph_fetch;
    logic ph_read;
    logic ph_write;
    logic off_nz;
    logic fetch_more;
    logic count_zero;
    logic cmd_known;
    logic mode_fill;
  } status_t;

  // Per-step control from sequencer to datapath
  typedef struct packed {
    act_e  act;
    emit_e emit;
  } ctrl_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] addr;
    logic [7:0]  data;
  } result_t;

  // Entry points of the program
  localparam step_t ST_IDLE      = 5'd0;
  localparam step_t ST_DISP      = 5'd1;
  localparam step_t ST_DISP_BASE = 5'd2;
  localparam step_t ST_WR        = 5'd6;
  localparam step_t ST_FETCH_REQ = 5'd9;
  localparam step_t ST_MD        = 5'd10;
  localparam step_t ST_FETCH     = 5'd13;
  localparam step_t ST_ACCESS    = 5'd19;
  localparam step_t ST_SRC_RD    = 5'd21;
  localparam step_t ST_FINISH    = 5'd22;
  localparam step_t ST_ACK       = 5'd23;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t uw;
    unique case (step)
      // wait for a transfer, then jump on its operation
      5'd0:  uw = '{J_WAIT, C_ALWAYS,        ST_DISP,      A_NONE,        E_NONE};
      5'd1:  uw = '{J_DISP, C_ALWAYS,        ST_DISP_BASE, A_NONE,        E_NONE};
      // jump table, one entry per operation
      5'd2:  uw = '{J_IF,   C_ALWAYS,        ST_WR,        A_NONE,        E_NONE};
      5'd3:  uw = '{J_IF,   C_ALWAYS,        ST_IDLE,      A_NONE,        E_REG_READ};
      5'd4:  uw = '{J_IF,   C_ALWAYS,        ST_MD,        A_NONE,        E_NONE};
      5'd5:  uw = '{J_IF,   C_ALWAYS,        ST_ACK,       A_NONE,        E_NONE};
      // register write
      5'd6:  uw = '{J_IF,   C_PH_BUSY,       ST_IDLE,      A_NONE,        E_NONE};
      5'd7:  uw = '{J_IF,   C_OFF_NZ,        ST_IDLE,      A_LP_WRITE,    E_NONE};
      5'd8:  uw = '{J_NEXT, C_ALWAYS,        ST_IDLE,      A_FETCH_START, E_NONE};
      5'd9:  uw = '{J_IF,   C_ALWAYS,        ST_IDLE,      A_NONE,        E_FETCH_REQ};
      // memory read data
      5'd10: uw = '{J_IF,   C_PH_FETCH,      ST_FETCH,     A_NONE,        E_NONE};
      5'd11: uw = '{J_IF,   C_PH_NOT_READ,   ST_IDLE,      A_NONE,        E_NONE};
      5'd12: uw = '{J_IF,   C_ALWAYS,        ST_IDLE,      A_COPY_WRITE,  E_COPY_WRITE};
      // job byte fetch and job start
      5'd13: uw = '{J_NEXT, C_ALWAYS,        ST_IDLE,      A_STORE_BYTE,  E_NONE};
      5'd14: uw = '{J_IF,   C_FETCH_MORE,    ST_FETCH_REQ, A_NONE,        E_NONE};
      5'd15: uw = '{J_NEXT, C_ALWAYS,        ST_IDLE,      A_MASK_ADDR,   E_NONE};
      5'd16: uw = '{J_IF,   C_COUNT_ZERO,    ST_FINISH,    A_NONE,        E_NONE};
      5'd17: uw = '{J_IF,   C_CMD_UNKNOWN,   ST_FINISH,    A_NONE,        E_NONE};
      5'd18: uw = '{J_NEXT, C_ALWAYS,        ST_IDLE,      A_SET_MODE,    E_NONE};
      // next memory access of the job
      5'd19: uw = '{J_IF,   C_MODE_NOT_FILL, ST_SRC_RD,    A_NONE,        E_NONE};
      5'd20: uw = '{J_IF,   C_ALWAYS,        ST_IDLE,      A_FILL_WRITE,  E_FILL_WRITE};
      5'd21: uw = '{J_IF,   C_ALWAYS,        ST_IDLE,      A_SRC_READ,    E_SRC_READ};
      5'd22: uw = '{J_IF,   C_ALWAYS,        ST_IDLE,      A_GO_IDLE,     E_FINISH};
      // memory write acknowledge
      5'd23: uw = '{J_IF,   C_PH_NOT_WRITE,  ST_IDLE,      A_NONE,        E_NONE};
      5'd24: uw = '{J_NEXT, C_ALWAYS,        ST_IDLE,      A_DEC_COUNT,   E_NONE};
      5'd25: uw = '{J_IF,   C_COUNT_NZ,      ST_ACCESS,    A_NONE,        E_NONE};
      5'd26: uw = '{J_IF,   C_ALWAYS,        ST_FINISH,    A_NONE,        E_NONE};
      default: uw = '{J_IF, C_ALWAYS,        ST_IDLE,      A_NONE,        E_NONE};
    endcase
    return uw;
  endfunction

endpackage
`default_nettype wire

[design/dma_job_list_copy_fill_engine_core.sv]
// Top level of the microcoded job-list DMA copy/fill engine.
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake              Payload
// in       into core  in_valid_i/in_stall_o   operation, reg_offset, write_value, mem_data
// out      from core  out_valid_o/out_stall_i kind, mem_address, out_data
// cfg      into core  cfg_we_i                cfg_wdata_i (controller revision)
//
// Each transfer runs a short microprogram, one ROM step per cycle while no
// emitting step holds; the last job byte runs the longest one, which starts
// the job. A new transfer is taken only once the program is back at its wait step.
// Reset puts the sequencer at its wait step, the engine idle, revision 2.
// A new transfer is taken while the last result still waits in the output
// register; a step that emits holds only while that register is stalled.
module dma_job_list_copy_fill_engine_core #(
  parameter int ADDR_WIDTH = 24
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_wdata_i,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [1:0]  operation_i,
  input  wire [1:0]  reg_offset_i,
  input  wire [7:0]  write_value_i,
  input  wire [7:0]  mem_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [1:0] kind_o,
  output logic [23:0] mem_address_o,
  output logic [7:0] out_data_o
);
  import dmajl_pkg::*;

  logic [1:0] version_q;

  // latched input transfer
  logic [1:0] op_q;
  logic [1:0] off_q;
  logic [7:0] wv_q;
  logic [7:0] md_q;

  logic    in_accept;
  logic    idle;
  logic    out_busy;
  ctrl_t   ctrl;
  status_t status;
  result_t result;

  logic    out_valid_q;
  result_t out_q;

  assign in_stall_o = !idle;
  assign in_accept  = in_valid_i && idle;
  assign out_busy   = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VERSION_RST;
    end else if (cfg_we_i) begin
      version_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= operation_i;
      off_q <= reg_offset_i;
      wv_q  <= write_value_i;
      md_q  <= mem_data_i;
    end
  end

  dmajl_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .op_i        (op_q),
    .status_i    (status),
    .out_busy_i  (out_busy),
    .idle_o      (idle),
    .ctrl_o      (ctrl)
  );

  dmajl_dpath #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .reg_offset_i  (off_q),
    .write_value_i (wv_q),
    .mem_data_i    (md_q),
    .dir_enable_i  (version_q == VERSION_DIR),
    .status_o      (status),
    .result_o      (result)
  );

  // output register: loads on an emitting step, drains when not stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit != E_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit != E_NONE) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign mem_address_o = out_q.addr;
  assign out_data_o    = out_q.data;

endmodule
`default_nettype wire

[design/dmajl_useq.sv]
// Microcode sequencer: step counter, ROM lookup and jump logic.
`timescale 1ns / 1ps
`default_nettype none
module dmajl_useq (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_accept_i,
  input  wire [1:0]         op_i,
  input  wire dmajl_pkg::status_t status_i,
  input  wire               out_busy_i,
  output logic              idle_o,
  output dmajl_pkg::ctrl_t  ctrl_o
);
  import dmajl_pkg::*;

  step_t  step_q, step_d;
  uword_t uw;
  logic   hold;
  logic   cond_true;

  assign uw   = ucode_rom(step_q);
  // an emitting step waits while the result register is still full and stalled
  assign hold = (uw.emit != E_NONE) && out_busy_i;

  assign idle_o = (step_q == ST_IDLE);

  always_comb begin
    unique case (uw.cnd)
      C_ALWAYS:        cond_true = 1'b1;
      C_PH_BUSY:       cond_true = !status_i.ph_idle;
      C_OFF_NZ:        cond_true = status_i.off_nz;
      C_PH_FETCH:      cond_true = status_i.ph_fetch;
      C_PH_NOT_READ:   cond_true = !status_i.ph_read;
      C_FETCH_MORE:    cond_true = status_i.fetch_more;
      C_COUNT_ZERO:    cond_true = status_i.count_zero;
      C_CMD_UNKNOWN:   cond_true = !status_i.cmd_known;
      C_MODE_NOT_FILL: cond_true = !status_i.mode_fill;
      C_PH_NOT_WRITE:  cond_true = !status_i.ph_write;
      C_COUNT_NZ:      cond_true = !status_i.count_zero;
      default:         cond_true = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (!hold) begin
      unique case (uw.jmp)
        J_NEXT: step_d = step_q + 5'd1;
        J_IF:   step_d = cond_true ? uw.target : step_q + 5'd1;
        J_WAIT: step_d = in_accept_i ? uw.target : step_q;
        J_DISP: step_d = uw.target + step_t'(op_i);
        default: step_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    if (hold) begin
      ctrl_o.act  = A_NONE;
      ctrl_o.emit = E_NONE;
    end else begin
      ctrl_o.act  = uw.act;
      ctrl_o.emit = uw.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

[design/dmajl_dpath.sv]
// Engine datapath: list pointer, job registers, address steppers, result mux.
`timescale 1ns / 1ps
`default_nettype none
module dmajl_dpath #(
  parameter int ADDR_WIDTH = 24
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire dmajl_pkg::ctrl_t ctrl_i,
  input  wire [1:0]          reg_offset_i,
  input  wire [7:0]          write_value_i,
  input  wire [7:0]          mem_data_i,
  input  wire                dir_enable_i,
  output dmajl_pkg::status_t status_o,
  output dmajl_pkg::result_t result_o
);
  import dmajl_pkg::*;

  localparam logic [23:0] AMASK =
    (ADDR_WIDTH >= 24) ? 24'hFFFFFF : 24'((64'd1 << ADDR_WIDTH) - 64'd1);

  logic [23:0] lp_q, lp_d;
  logic [3:0]  fidx_q, fidx_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] count_q, count_d;
  logic [23:0] src_q, src_d;
  logic [23:0] dst_q, dst_d;
  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;

  logic src_down, dst_down;

  function automatic logic [23:0] addr_step(input logic [23:0] a, input logic down);
    logic [23:0] r;
    r = down ? (a - 24'd1) : (a + 24'd1);
    return r & AMASK;
  endfunction

  assign src_down = (mode_q == MODE_SRCDN) || (mode_q == MODE_DOWN);
  assign dst_down = (mode_q == MODE_DSTDN) || (mode_q == MODE_DOWN);

  always_comb begin
    status_o.ph_idle    = (phase_q == PH_IDLE);
    status_o.ph_fetch   = (phase_q == PH_FETCH);
    status_o.ph_read    = (phase_q == PH_READ);
    status_o.ph_write   = (phase_q == PH_WRITE);
    status_o.off_nz     = (reg_offset_i != OFF_LOW);
    status_o.fetch_more = (fidx_q < JOB_BYTES);
    status_o.count_zero = (count_q == 16'd0);
    status_o.cmd_known  = (cmd_q == CMD_COPY) || (cmd_q == CMD_FILL) || (cmd_q == CMD_DOWN);
    status_o.mode_fill  = (mode_q == MODE_FILL);
  end

  always_comb begin
    lp_d    = lp_q;
    fidx_d  = fidx_q;
    cmd_d   = cmd_q;
    count_d = count_q;
    src_d   = src_q;
    dst_d   = dst_q;
    mode_d  = mode_q;
    phase_d = phase_q;
    unique case (ctrl_i.act)
      A_NONE: ;
      A_LP_WRITE: begin
        unique case (reg_offset_i)
          OFF_LOW:  lp_d[7:0]   = write_value_i;
          OFF_MID:  lp_d[15:8]  = write_value_i;
          OFF_BANK: lp_d[23:16] = write_value_i;
          default: ;
        endcase
      end
      A_FETCH_START: begin
        fidx_d  = 4'd0;
        phase_d = PH_FETCH;
      end
      A_STORE_BYTE: begin
        unique case (fidx_q)
          4'd0: cmd_d          = mem_data_i;
          4'd1: count_d[7:0]   = mem_data_i;
          4'd2: count_d[15:8]  = mem_data_i;
          4'd3: src_d[7:0]     = mem_data_i;
          4'd4: src_d[15:8]    = mem_data_i;
          4'd5: src_d[23:16]   = mem_data_i;
          4'd6: dst_d[7:0]     = mem_data_i;
          4'd7: dst_d[15:8]    = mem_data_i;
          4'd8: dst_d[23:16]   = mem_data_i;
          default: ;
        endcase
        fidx_d = fidx_q + 4'd1;
      end
      A_MASK_ADDR: begin
        src_d = src_q & AMASK;
        dst_d = dst_q & AMASK;
      end
      A_SET_MODE: begin
        unique case (cmd_q)
          CMD_COPY: begin
            if (dir_enable_i && (src_q[22] || dst_q[22])) begin
              if (!src_q[22]) begin
                dst_d  = dst_q & ~DIR_BIT;
                mode_d = MODE_DSTDN;
              end else if (!dst_q[22]) begin
                src_d  = src_q & ~DIR_BIT;
                mode_d = MODE_SRCDN;
              end else begin
                // reverse copy: both pre-decremented, then a plain down copy
                src_d  = addr_step(src_q & ~DIR_BIT, 1'b1);
                dst_d  = addr_step(dst_q & ~DIR_BIT, 1'b1);
                mode_d = MODE_DOWN;
              end
            end else begin
              mode_d = MODE_UP;
            end
          end
          CMD_FILL: mode_d = MODE_FILL;
          CMD_DOWN: mode_d = MODE_DOWN;
          default: ;
        endcase
      end
      A_FILL_WRITE: begin
        dst_d   = addr_step(dst_q, 1'b0);
        phase_d = PH_WRITE;
      end
      A_SRC_READ: begin
        src_d   = addr_step(src_q, src_down);
        phase_d = PH_READ;
      end
      A_COPY_WRITE: begin
        dst_d   = addr_step(dst_q, dst_down);
        phase_d = PH_WRITE;
      end
      A_GO_IDLE: phase_d = PH_IDLE;
      A_DEC_COUNT: count_d = count_q - 16'd1;
      default: ;
    endcase
  end

  always_comb begin
    result_o.kind = K_RD_REQ;
    result_o.addr = 24'd0;
    result_o.data = 8'd0;
    unique case (ctrl_i.emit)
      E_NONE: ;
      E_REG_READ: begin
        result_o.kind = K_REG_DATA;
        result_o.data = READ_VALUE;
      end
      E_FETCH_REQ: begin
        result_o.kind = K_RD_REQ;
        result_o.addr = (lp_q + {20'd0, fidx_q}) & AMASK;
      end
      E_COPY_WRITE: begin
        result_o.kind = K_WR_REQ;
        result_o.addr = dst_q;
        result_o.data = mem_data_i;
      end
      E_FILL_WRITE: begin
        result_o.kind = K_WR_REQ;
        result_o.addr = dst_q;
        result_o.data = src_q[7:0];
      end
      E_SRC_READ: begin
        result_o.kind = K_RD_REQ;
        result_o.addr = src_q;
      end
      E_FINISH: result_o.kind = K_DONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q    <= 24'd0;
      fidx_q  <= 4'd0;
      cmd_q   <= 8'd0;
      count_q <= 16'd0;
      src_q   <= 24'd0;
      dst_q   <= 24'd0;
      mode_q  <= MODE_UP;
      phase_q <= PH_IDLE;
    end else begin
      lp_q    <= lp_d;
      fidx_q  <= fidx_d;
      cmd_q   <= cmd_d;
      count_q <= count_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      mode_q  <= mode_d;
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire
